[rtl/core/bsrc_pkg.sv]
// bsrc_pkg: shared constants, codes and types of the safe request checker
// no dependencies; used by the channel interfaces, the row unit and the top level
package bsrc_pkg;

   localparam int NUM_PROCESSES_DEFAULT = 8;
   localparam int NUM_RESOURCES         = 3;
   localparam int CMD_W                 = 2;
   localparam int PROC_W                = 3;
   localparam int AMOUNT_W              = 8;
   localparam int WORK_W                = 12;
   localparam int STATUS_W              = 2;

   localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_ROW  = 2'd0,
      CMD_SET_AVAIL = 2'd1,
      CMD_REQUEST   = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REFUSED  = 2'd1,
      STATUS_UNSAFE   = 2'd2,
      STATUS_OVER_MAX = 2'd3
   } status_type;

   typedef logic [AMOUNT_W-1:0] amount_type;
   typedef amount_type [NUM_RESOURCES-1:0] amount_vec_type;
   typedef logic [WORK_W-1:0] work_type;
   typedef work_type [NUM_RESOURCES-1:0] work_vec_type;

   // verdict of one row check in the safety scan
   typedef struct packed {
      logic         fits;
      work_vec_type work_sum;
   } row_result_type;

endpackage

[rtl/core/bsrc_if.sv]
// bsrc channel interfaces: request beats in, response beats out
// depends on bsrc_pkg for field widths
interface bsrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsrc_pkg::CMD_W-1:0]    command;
   logic [bsrc_pkg::PROC_W-1:0]   process;
   logic [bsrc_pkg::AMOUNT_W-1:0] amount_0;
   logic [bsrc_pkg::AMOUNT_W-1:0] amount_1;
   logic [bsrc_pkg::AMOUNT_W-1:0] amount_2;
   logic [bsrc_pkg::AMOUNT_W-1:0] held_0;
   logic [bsrc_pkg::AMOUNT_W-1:0] held_1;
   logic [bsrc_pkg::AMOUNT_W-1:0] held_2;

   modport source (output valid, command, process, amount_0, amount_1, amount_2,
                   held_0, held_1, held_2, input ready);
   modport sink   (input valid, command, process, amount_0, amount_1, amount_2,
                   held_0, held_1, held_2, output ready);
endinterface

interface bsrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          granted;
   logic [bsrc_pkg::STATUS_W-1:0] status;

   modport source (output valid, granted, status, input ready);
   modport sink   (input valid, granted, status, output ready);
endinterface

[rtl/core/bsrc_row_unit.sv]
// bsrc_row_unit: shared row check of the safety scan
// need <= work for every resource, and the saturated sum work + alloc; uses bsrc_pkg
module bsrc_row_unit (
   input  bsrc_pkg::amount_vec_type need,
   input  bsrc_pkg::amount_vec_type alloc,
   input  bsrc_pkg::work_vec_type   work,
   output bsrc_pkg::row_result_type result
);

   logic [bsrc_pkg::WORK_W:0] sum [bsrc_pkg::NUM_RESOURCES];

   always_comb begin
      result.fits = 1'b1;
      for (int r = 0; r < bsrc_pkg::NUM_RESOURCES; r++) begin
         if (bsrc_pkg::WORK_W'(need[r]) > work[r]) begin
            result.fits = 1'b0;
         end
         sum[r] = {1'b0, work[r]} + (bsrc_pkg::WORK_W + 1)'(alloc[r]);
         // saturate at the top of the work range
         if (sum[r] > {1'b0, bsrc_pkg::WORK_MAX}) begin
            result.work_sum[r] = bsrc_pkg::WORK_MAX;
         end else begin
            result.work_sum[r] = sum[r][bsrc_pkg::WORK_W-1:0];
         end
      end
   end

endmodule

[rtl/core/bankers_safe_request_check.sv]
// bankers_safe_request_check: request checker with deadlock avoidance by safety scan
// depends on bsrc_pkg, bsrc_req_if / bsrc_rsp_if and bsrc_row_unit
//
//   channel   dir   beat contents                                        handshake
//   req_bus   in    command, process, amount_0..2, held_0..2             valid / ready
//   rsp_bus   out   granted, status                                      valid / ready
//
// load row and set available go from the exec state to done; a resource request that
// passes its range, need and available checks runs the safety scan before done:
// the safety scan checks one process row per cycle in the shared row unit, in passes
// over all rows, until every process is finished or a pass makes no progress
// reset clears the need and allocation tables, the available vector and the channels
// req_bus.ready is high only while the sequencer is idle; a response waiting on
// rsp_bus does not hold off the next request beat, only the handover of its result
module bankers_safe_request_check #(
   parameter int NUM_PROCESSES = bsrc_pkg::NUM_PROCESSES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   bsrc_req_if.sink        req_bus,
   bsrc_rsp_if.source      rsp_bus
);

   localparam int ROW_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_PROCESSES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_ROLLBACK,
      ST_DONE
   } state_type;

   // sequencer and captured request
   state_type                    state_ff, state_in;
   logic [bsrc_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [bsrc_pkg::PROC_W-1:0]  proc_ff, proc_in;
   bsrc_pkg::amount_vec_type     amt_ff, amt_in;
   bsrc_pkg::amount_vec_type     held_ff, held_in;

   // banker state
   bsrc_pkg::amount_vec_type     need_ff [NUM_PROCESSES];
   bsrc_pkg::amount_vec_type     need_in [NUM_PROCESSES];
   bsrc_pkg::amount_vec_type     alloc_ff [NUM_PROCESSES];
   bsrc_pkg::amount_vec_type     alloc_in [NUM_PROCESSES];
   bsrc_pkg::amount_vec_type     avail_ff, avail_in;

   // safety scan scratch
   bsrc_pkg::work_vec_type       work_ff, work_in;
   logic [NUM_PROCESSES-1:0]     fin_ff, fin_in;
   logic [ROW_W-1:0]             ptr_ff, ptr_in;
   logic                         prog_ff, prog_in;

   // result waiting for the output register, and the output register itself
   logic                         res_granted_ff, res_granted_in;
   bsrc_pkg::status_type         res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_granted_ff, rsp_granted_in;
   bsrc_pkg::status_type         rsp_status_ff, rsp_status_in;

   // row read port and shared row check
   logic                         in_range;
   logic [ROW_W-1:0]             proc_row;
   logic [ROW_W-1:0]             rd_row;
   bsrc_pkg::amount_vec_type     rd_need;
   bsrc_pkg::amount_vec_type     rd_alloc;
   bsrc_pkg::row_result_type     row_res;
   logic                         req_bad;
   logic                         load_bad;
   logic                         hit;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.granted = rsp_granted_ff;
   assign rsp_bus.status  = rsp_status_ff;

   assign in_range = (int'(proc_ff) < NUM_PROCESSES);
   assign proc_row = in_range ? ROW_W'(proc_ff) : '0;
   assign rd_row   = (state_ff == ST_SCAN) ? ptr_ff : proc_row;
   assign rd_need  = need_ff[rd_row];
   assign rd_alloc = alloc_ff[rd_row];

   bsrc_row_unit u_row_unit (
      .need   (rd_need),
      .alloc  (rd_alloc),
      .work   (work_ff),
      .result (row_res)
   );

   always_comb begin
      req_bad  = 1'b0;
      load_bad = 1'b0;
      for (int r = 0; r < bsrc_pkg::NUM_RESOURCES; r++) begin
         if (amt_ff[r] > rd_need[r] || amt_ff[r] > avail_ff[r]) begin
            req_bad = 1'b1;
         end
         if (held_ff[r] > amt_ff[r]) begin
            load_bad = 1'b1;
         end
      end
   end

   assign hit = !fin_ff[ptr_ff] && row_res.fits;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      proc_in        = proc_ff;
      amt_in         = amt_ff;
      held_in        = held_ff;
      need_in        = need_ff;
      alloc_in       = alloc_ff;
      avail_in       = avail_ff;
      work_in        = work_ff;
      fin_in         = fin_ff;
      ptr_in         = ptr_ff;
      prog_in        = prog_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      // response register drains on its own beat
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in     = req_bus.command;
               proc_in    = req_bus.process;
               amt_in[0]  = req_bus.amount_0;
               amt_in[1]  = req_bus.amount_1;
               amt_in[2]  = req_bus.amount_2;
               held_in[0] = req_bus.held_0;
               held_in[1] = req_bus.held_1;
               held_in[2] = req_bus.held_2;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_granted_in = 1'b0;
            res_status_in  = bsrc_pkg::STATUS_REFUSED;
            state_in       = ST_DONE;
            case (cmd_ff)
               bsrc_pkg::CMD_SET_AVAIL: begin
                  avail_in       = amt_ff;
                  res_granted_in = 1'b1;
                  res_status_in  = bsrc_pkg::STATUS_OK;
               end
               bsrc_pkg::CMD_LOAD_ROW: begin
                  if (in_range) begin
                     if (load_bad) begin
                        res_status_in = bsrc_pkg::STATUS_OVER_MAX;
                     end else begin
                        for (int r = 0; r < bsrc_pkg::NUM_RESOURCES; r++) begin
                           alloc_in[proc_row][r] = held_ff[r];
                           need_in[proc_row][r]  = amt_ff[r] - held_ff[r];
                        end
                        res_granted_in = 1'b1;
                        res_status_in  = bsrc_pkg::STATUS_OK;
                     end
                  end
               end
               bsrc_pkg::CMD_REQUEST: begin
                  if (in_range && !req_bad) begin
                     // tentative grant, then scan from the reduced available vector
                     for (int r = 0; r < bsrc_pkg::NUM_RESOURCES; r++) begin
                        avail_in[r]           = avail_ff[r] - amt_ff[r];
                        alloc_in[proc_row][r] = rd_alloc[r] + amt_ff[r];
                        need_in[proc_row][r]  = rd_need[r] - amt_ff[r];
                        work_in[r]            = bsrc_pkg::WORK_W'(avail_ff[r] - amt_ff[r]);
                     end
                     fin_in   = '0;
                     ptr_in   = '0;
                     prog_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  // unused command: refused, nothing changes
               end
            endcase
         end

         ST_SCAN: begin
            if (hit) begin
               fin_in[ptr_ff] = 1'b1;
               work_in        = row_res.work_sum;
               prog_in        = 1'b1;
            end
            if (&fin_in) begin
               res_granted_in = 1'b1;
               res_status_in  = bsrc_pkg::STATUS_OK;
               state_in       = ST_DONE;
            end else if (ptr_ff == LAST_ROW) begin
               if (prog_ff || hit) begin
                  ptr_in  = '0;
                  prog_in = 1'b0;
               end else begin
                  // a full pass with no process able to finish: unsafe
                  state_in = ST_ROLLBACK;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_ROLLBACK: begin
            for (int r = 0; r < bsrc_pkg::NUM_RESOURCES; r++) begin
               avail_in[r]           = avail_ff[r] + amt_ff[r];
               alloc_in[proc_row][r] = rd_alloc[r] - amt_ff[r];
               need_in[proc_row][r]  = rd_need[r] + amt_ff[r];
            end
            res_granted_in = 1'b0;
            res_status_in  = bsrc_pkg::STATUS_UNSAFE;
            state_in       = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         avail_ff     <= '0;
         for (int p = 0; p < NUM_PROCESSES; p++) begin
            need_ff[p]  <= '0;
            alloc_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         avail_ff     <= avail_in;
         need_ff      <= need_in;
         alloc_ff     <= alloc_in;
      end
      cmd_ff         <= cmd_in;
      proc_ff        <= proc_in;
      amt_ff         <= amt_in;
      held_ff        <= held_in;
      work_ff        <= work_in;
      fin_ff         <= fin_in;
      ptr_ff         <= ptr_in;
      prog_ff        <= prog_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule

[dv/bsrc_checker.sv]
// bsrc_checker: watches the request and response channels of the safe request checker,
// predicts each response from its own copy of the tables and compares in order
// depends on bsrc_pkg and the bsrc_req_if / bsrc_rsp_if interfaces
`timescale 1ns / 1ps

module bsrc_checker #(
   parameter int NUM_PROCESSES = bsrc_pkg::NUM_PROCESSES_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   bsrc_req_if   req_bus,
   bsrc_rsp_if   rsp_bus,
   output int    fail_count,
   output int    pending,
   output int    checked_count,
   output int    granted_count
);
   import bsrc_pkg::*;

   typedef struct packed {
      logic       granted;
      status_type status;
   } outcome_type;

   amount_type  need_rows [NUM_PROCESSES][NUM_RESOURCES];
   amount_type  held_rows [NUM_PROCESSES][NUM_RESOURCES];
   amount_type  avail_now [NUM_RESOURCES];
   outcome_type expected_outcomes [$];

   // true when some order lets every process run to completion
   function automatic bit all_can_finish();
      work_type         work [NUM_RESOURCES];
      bit               done [NUM_PROCESSES];
      int               pick;
      bit               fits;
      logic [WORK_W:0]  total;
      for (int r = 0; r < NUM_RESOURCES; r++) work[r] = work_type'(avail_now[r]);
      for (int p = 0; p < NUM_PROCESSES; p++) done[p] = 1'b0;
      for (int round = 0; round < NUM_PROCESSES; round++) begin
         pick = -1;
         for (int p = 0; p < NUM_PROCESSES && pick < 0; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NUM_RESOURCES; r++)
                  if (work_type'(need_rows[p][r]) > work[r]) fits = 1'b0;
               if (fits) pick = p;
            end
         end
         if (pick < 0) return 1'b0;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            total   = work[r] + held_rows[pick][r];
            work[r] = (total > WORK_MAX) ? WORK_MAX : total[WORK_W-1:0];
         end
         done[pick] = 1'b1;
      end
      return 1'b1;
   endfunction

   // applies one request beat to the shadow tables and returns its response
   function automatic outcome_type decide(logic [CMD_W-1:0] cmd, logic [PROC_W-1:0] proc,
                                          amount_type amt [NUM_RESOURCES],
                                          amount_type held [NUM_RESOURCES]);
      outcome_type res;
      bit          bad;
      int          row;
      res.granted = 1'b0;
      res.status  = STATUS_REFUSED;
      row         = int'(proc);
      bad         = 1'b0;
      if (cmd == CMD_SET_AVAIL) begin
         for (int r = 0; r < NUM_RESOURCES; r++) avail_now[r] = amt[r];
         res = '{1'b1, STATUS_OK};
      end else if ((cmd == CMD_LOAD_ROW || cmd == CMD_REQUEST) && row < NUM_PROCESSES) begin
         if (cmd == CMD_LOAD_ROW) begin
            for (int r = 0; r < NUM_RESOURCES; r++)
               if (held[r] > amt[r]) bad = 1'b1;
            if (bad) begin
               res.status = STATUS_OVER_MAX;
            end else begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  held_rows[row][r] = held[r];
                  need_rows[row][r] = amt[r] - held[r];
               end
               res = '{1'b1, STATUS_OK};
            end
         end else begin
            for (int r = 0; r < NUM_RESOURCES; r++)
               if (amt[r] > need_rows[row][r] || amt[r] > avail_now[r]) bad = 1'b1;
            if (!bad) begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  avail_now[r]      = avail_now[r] - amt[r];
                  held_rows[row][r] = held_rows[row][r] + amt[r];
                  need_rows[row][r] = need_rows[row][r] - amt[r];
               end
               if (all_can_finish()) begin
                  res = '{1'b1, STATUS_OK};
               end else begin
                  // no safe order: undo the tentative grant
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                     avail_now[r]      = avail_now[r] + amt[r];
                     held_rows[row][r] = held_rows[row][r] - amt[r];
                     need_rows[row][r] = need_rows[row][r] + amt[r];
                  end
                  res.status = STATUS_UNSAFE;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(string what);
      if (fail_count < 10) $display("%0t: response %0d: %s", $time, checked_count, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      amount_type  amt  [NUM_RESOURCES];
      amount_type  held [NUM_RESOURCES];
      outcome_type want;
      if (reset) begin
         for (int p = 0; p < NUM_PROCESSES; p++)
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               need_rows[p][r] = '0;
               held_rows[p][r] = '0;
            end
         for (int r = 0; r < NUM_RESOURCES; r++) avail_now[r] = '0;
         expected_outcomes.delete();
         fail_count    = 0;
         checked_count = 0;
         granted_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            amt  = '{req_bus.amount_0, req_bus.amount_1, req_bus.amount_2};
            held = '{req_bus.held_0, req_bus.held_1, req_bus.held_2};
            expected_outcomes.push_back(decide(req_bus.command, req_bus.process, amt, held));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_count++;
            if (expected_outcomes.size() == 0) begin
               note_mismatch($sformatf("unexpected beat, granted %b status %0d",
                                       rsp_bus.granted, rsp_bus.status));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_bus.granted !== want.granted || rsp_bus.status !== want.status)
                  note_mismatch($sformatf("expected granted %b status %s, got granted %b status %0d",
                                          want.granted, want.status.name(),
                                          rsp_bus.granted, rsp_bus.status));
               else if (want.granted)
                  granted_count++;
            end
         end
      end
      pending = expected_outcomes.size();
   end

endmodule

[dv/tb.sv]
// tb: top of the safe request checker testbench, drives request beats and response stalls
// depends on bsrc_pkg, the channel interfaces, bankers_safe_request_check and bsrc_checker
`timescale 1ns / 1ps

module tb;
   import bsrc_pkg::*;

   localparam int PROCS = NUM_PROCESSES_DEFAULT;
   // the command field has one code the block does not use
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 2000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset;
   bit   steady;          // no idling on either side while set
   int   beats_sent;
   int   scenarios;
   int   fail_count, pending, checked_count, granted_count;

   bsrc_req_if req_bus ();
   bsrc_rsp_if rsp_bus ();

   bankers_safe_request_check #(.NUM_PROCESSES(PROCS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bsrc_checker #(.NUM_PROCESSES(PROCS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .granted_count (granted_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side stalls about 7 percent of the time, never during the steady stretch
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (steady || $urandom_range(0, 99) >= 7);
   end

   // one request beat; valid stays high from beat to beat unless an idle gap is taken,
   // so it is never lowered and raised in the same time step
   task automatic send_beat(logic [CMD_W-1:0] cmd, int p, int a0, int a1, int a2,
                            int h0, int h1, int h2);
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.process  <= p[PROC_W-1:0];
      req_bus.amount_0 <= a0[AMOUNT_W-1:0];
      req_bus.amount_1 <= a1[AMOUNT_W-1:0];
      req_bus.amount_2 <= a2[AMOUNT_W-1:0];
      req_bus.held_0   <= h0[AMOUNT_W-1:0];
      req_bus.held_1   <= h1[AMOUNT_W-1:0];
      req_bus.held_2   <= h2[AMOUNT_W-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // held fields are don't-care outside load row, so they get random bits there
   task automatic set_avail(int a0, int a1, int a2);
      send_beat(CMD_SET_AVAIL, $urandom_range(0, 7), a0, a1, a2,
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   task automatic load_row(int p, int m0, int m1, int m2, int h0, int h1, int h2);
      send_beat(CMD_LOAD_ROW, p, m0, m1, m2, h0, h1, h2);
   endtask

   task automatic ask(int p, int a0, int a1, int a2);
      send_beat(CMD_REQUEST, p, a0, a1, a2,
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // small claims keep grants, refusals and unsafe rollbacks all frequent;
   // about one row in twelve carries an allocation above its maximum
   task automatic load_random_row(int p);
      int m [3];
      int h [3];
      for (int r = 0; r < 3; r++) begin
         m[r] = $urandom_range(0, 12);
         h[r] = $urandom_range(0, m[r]);
      end
      if ($urandom_range(0, 11) == 0) h[$urandom_range(0, 2)] = 13;
      load_row(p, m[0], m[1], m[2], h[0], h[1], h[2]);
   endtask

   task automatic set_random_avail();
      if ($urandom_range(0, 7) == 0)
         set_avail($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
         set_avail($urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(0, 24));
   endtask

   initial begin
      int pick;
      int wait_cycles;
      reset            <= 1'b1;
      steady           <= 1'b0;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= CMD_LOAD_ROW;
      req_bus.process  <= '0;
      req_bus.amount_0 <= '0;
      req_bus.amount_1 <= '0;
      req_bus.amount_2 <= '0;
      req_bus.held_0   <= '0;
      req_bus.held_1   <= '0;
      req_bus.held_2   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      set_avail(0, 0, 0);
      ask(0, 0, 0, 0);                        // zero request on empty tables is safe
      send_beat(CMD_UNUSED, 5, 255, 255, 255, 255, 255, 255);
      load_row(0, 255, 255, 255, 0, 0, 0);    // full claim, nothing held
      load_row(1, 255, 0, 255, 255, 0, 255);  // fully held, need zero
      load_row(2, 0, 0, 0, 1, 0, 0);          // held above maximum, first resource
      load_row(3, 200, 7, 9, 200, 8, 9);      // held above maximum, middle resource
      set_avail(255, 255, 255);
      ask(0, 0, 0, 0);
      ask(1, 1, 0, 0);                        // beyond need
      ask(0, 255, 255, 255);                  // whole need and whole pool
      set_avail(3, 3, 3);
      load_row(0, 10, 10, 10, 5, 5, 5);
      load_row(1, 4, 4, 4, 2, 2, 2);
      ask(0, 2, 2, 2);                        // leaves no safe order, rolled back
      ask(1, 2, 2, 2);                        // releases enough for process 0
      ask(0, 4, 0, 0);                        // within need, beyond available
      set_avail(0, 0, 0);
      ask(3, 0, 0, 0);                        // zero request in an unsafe state
      load_row(7, 255, 255, 255, 255, 255, 255);
      ask(7, 1, 0, 0);
      ask(6, 0, 0, 0);

      // random part: scenarios of a fresh pool and rows followed by mostly requests
      beats_sent = 0;
      scenarios  = 0;
      while (beats_sent < RANDOM_BEATS) begin
         scenarios++;
         steady <= (beats_sent >= 600 && beats_sent < 1000);
         set_random_avail();
         for (int p = 0; p < PROCS; p++) load_random_row(p);
         repeat ($urandom_range(15, 35)) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               ask($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 3));
            else if (pick < 82)
               load_random_row($urandom_range(0, 7));
            else if (pick < 88)
               set_random_avail();
            else if (pick < 95)
               // noise over the whole field range
               send_beat(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 7),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
            else
               send_beat(CMD_UNUSED, $urandom_range(0, 7),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
      req_bus.valid <= 1'b0;
      steady        <= 1'b0;

      // drain: every predicted response must come back
      for (wait_cycles = 0; pending != 0 && wait_cycles < 5000; wait_cycles++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d random beats in %0d scenarios after the directed corners",
               beats_sent, scenarios);
      $display("%0d responses checked, %0d granted, %0d still outstanding",
               checked_count, granted_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
